FILE: rtl/deadzone_expo_response_curve_assert.svh
// assertion macros for the response curve block
`ifndef DEADZONE_EXPO_RESPONSE_CURVE_ASSERT_SVH
`define DEADZONE_EXPO_RESPONSE_CURVE_ASSERT_SVH
`ifndef ASSERT_OFF
`define DZC_ASSERT(lbl, ck, rstn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);
`define DZC_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define DZC_ASSERT(lbl, ck, rstn, prop, msg)
`define DZC_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg)
`endif
`endif

FILE: rtl/dzc_pkg.sv
package dzc_pkg;

  localparam int FRAC_BITS = 14;
  localparam int LOG_STEPS = 16;
  localparam int Q30       = 30;
  localparam int MAN_W     = Q30 + 1;
  localparam int NRM_W     = 5;
  localparam int POS_W     = 16;

  localparam int ONE_VAL   = 1 << FRAC_BITS;
  localparam int GAIN_MIN  = 2560;
  localparam int GAIN_MAX  = 25600;
  localparam int SCALE_MIN = 3277;
  localparam int SCALE_MAX = 32768;
  localparam int DEAD_MAX  = (ONE_VAL * 4) / 5;
  localparam int SHAPE_MIN = 6554;
  localparam int SHAPE_MAX = 58982;
  localparam int GAIN_RST  = 5120;
  localparam int SCALE_RST = 32768;
  localparam int SHAPE_RST = 32768;
  localparam int GAIN_FB   = 8;

  localparam int MQ_DEPTH  = 4;
  localparam int MQ_AW     = 2;
  localparam int OQ_DEPTH  = 2;
  localparam int OQ_AW     = 1;

  typedef enum logic [2:0] {
    CFG_GAIN  = 3'd0,
    CFG_SCALE = 3'd1,
    CFG_DEAD  = 3'd2,
    CFG_BIAS  = 3'd3,
    CFG_SHAPE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [14:0]        gain;
    logic [15:0]        scale;
    logic [13:0]        dead;
    logic signed [15:0] bias;
    logic [15:0]        shape;
  } cfg_t;

  typedef struct packed {
    logic neg;
    logic dead;
    logic zero;
  } side_t;

  typedef struct packed {
    side_t             sd;
    logic [NRM_W-1:0]  nx;
    logic [MAN_W-1:0]  mx;
  } mid_item_t;

  typedef struct packed {
    logic [POS_W-1:0] mapped;
    logic             dead;
  } res_item_t;

  function automatic logic [NRM_W-1:0] msb_idx(logic [15:0] v);
    logic [NRM_W-1:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) r = NRM_W'(i);
    end
    return r;
  endfunction

  function automatic logic [MAN_W-1:0] norm_man(logic [15:0] v, logic [NRM_W-1:0] n);
    return {{(MAN_W-16){1'b0}}, v} << (NRM_W'(Q30) - n);
  endfunction

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] vv;
    r  = '0;
    b  = 64'd1 << 62;
    vv = v;
    for (int i = 0; i < 32; i++) begin
      if (vv >= r + b) begin
        vv = vv - (r + b);
        r  = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [MAN_W-1:0] root_val(int k);
    logic [63:0] r;
    r = 64'd2 << Q30;
    for (int i = 0; i < k; i++) begin
      r = isqrt64(r << Q30);
    end
    return r[MAN_W-1:0];
  endfunction

endpackage

FILE: rtl/dzc_front.sv
module dzc_front import dzc_pkg::*; (
  input  logic [POS_W-1:0] raw_position,
  input  cfg_t             cfg,
  output mid_item_t        item
);

  logic signed [16:0] x;
  logic [16:0]        mag;
  logic [15:0]        magc;

  always_comb begin
    x    = 17'($signed(raw_position)) + 17'(cfg.bias);
    mag  = x[16] ? 17'(-x) : 17'(x);
    magc = (mag > 17'(ONE_VAL)) ? 16'(ONE_VAL) : mag[15:0];
    item.sd.neg  = x[16];
    item.sd.dead = mag < {3'b0, cfg.dead};
    item.sd.zero = (mag == '0);
    item.nx      = msb_idx(magc);
    item.mx      = norm_man(magc, item.nx);
  end

endmodule

FILE: rtl/dzc_midq.sv
module dzc_midq import dzc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  mid_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output mid_item_t head
);

  mid_item_t        mem_r [MQ_DEPTH];
  logic [MQ_AW-1:0] wptr_r;
  logic [MQ_AW-1:0] rptr_r;
  logic [MQ_AW:0]   cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == (MQ_AW+1)'(MQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + 1'b1;
      if (do_pop) rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_r + (MQ_AW+1)'(do_push) - (MQ_AW+1)'(do_pop);
    end
  end

endmodule

FILE: rtl/dzc_back.sv
module dzc_back import dzc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  mid_item_t q_item,
  input  logic      q_empty,
  output logic      q_pop,
  input  cfg_t      cfg,
  input  logic      res_full,
  output logic      res_push,
  output res_item_t res_item
);

  localparam int L      = LOG_STEPS;
  localparam int D      = 3 * L + 6;
  localparam int LOG_W  = L + 6;
  localparam int LP_W   = LOG_W + 1;
  localparam int EXP_NW = 8;
  localparam int P_W    = MAN_W + 3;
  localparam int PH     = 17;
  localparam int AX_W   = L + 4;
  localparam int PR_W   = AX_W + PH;
  localparam int UT_W   = PR_W + PH + 1;
  localparam int QV_W   = UT_W - Q30;
  localparam int Y_W    = 16;

  typedef struct packed {
    side_t            sd;
    logic [NRM_W-1:0] nx;
    logic [MAN_W-1:0] mx;
    logic [L-1:0]     fx;
    logic [NRM_W-1:0] ng;
    logic [MAN_W-1:0] mg;
    logic [L-1:0]     fg;
  } log_st_t;

  typedef struct packed {
    side_t                     sd;
    logic signed [LOG_W-1:0]   lx;
    logic signed [EXP_NW-1:0]  n;
    logic [L-1:0]              f;
    logic [MAN_W-1:0]          m;
  } exp_st_t;

  function automatic logic [MAN_W+L-1:0] sq_step(logic [MAN_W-1:0] m, logic [L-1:0] f);
    logic [2*MAN_W-1:0] sq;
    logic [MAN_W:0]     m2;
    sq = {{MAN_W{1'b0}}, m} * {{MAN_W{1'b0}}, m};
    m2 = sq[Q30+MAN_W:Q30];
    if (m2[MAN_W]) return {m2[MAN_W:1], f[L-2:0], 1'b1};
    return {m2[MAN_W-1:0], f[L-2:0], 1'b0};
  endfunction

  function automatic log_st_t log_adv(log_st_t s);
    log_st_t o;
    o = s;
    {o.mx, o.fx} = sq_step(s.mx, s.fx);
    {o.mg, o.fg} = sq_step(s.mg, s.fg);
    return o;
  endfunction

  function automatic exp_st_t exp_adv(exp_st_t s, logic [MAN_W-1:0] rt, logic b);
    logic [2*MAN_W-1:0] pr;
    exp_st_t            o;
    o  = s;
    pr = {{MAN_W{1'b0}}, s.m} * {{MAN_W{1'b0}}, rt};
    if (b) o.m = pr[Q30+MAN_W-1:Q30];
    return o;
  endfunction

  logic       adv;
  logic [D:1] vld_r;

  assign adv      = !res_full;
  assign q_pop    = adv && !q_empty;
  assign res_push = adv && vld_r[D];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[D-1:1], !q_empty};
    end
  end

  // log2 of magnitude and gain
  log_st_t a_in;
  log_st_t a_r [1:L];

  always_comb begin
    a_in.sd = q_item.sd;
    a_in.nx = q_item.nx;
    a_in.mx = q_item.mx;
    a_in.fx = '0;
    a_in.ng = msb_idx({1'b0, cfg.gain});
    a_in.mg = norm_man({1'b0, cfg.gain}, a_in.ng);
    a_in.fg = '0;
  end

  for (genvar k = 1; k <= L; k++) begin : g_log
    if (k == 1) begin : g_first
      always_ff @(posedge clk) begin
        if (adv) a_r[k] <= log_adv(a_in);
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (adv) a_r[k] <= log_adv(a_r[k-1]);
      end
    end
  end

  // exponent p in log domain
  logic [5:0]               eg;
  logic [5:0]               ex;
  logic signed [LOG_W-1:0]  lg_v;
  logic signed [LOG_W-1:0]  lx_v;
  logic signed [16:0]       ds;
  logic signed [LOG_W+16:0] lp_prod;
  logic signed [LP_W-1:0]   lp_r;
  logic signed [LOG_W-1:0]  lx_r;
  side_t                    sd_p0_r;

  always_comb begin
    eg      = 6'({1'b0, a_r[L].ng}) - 6'(GAIN_FB);
    ex      = 6'({1'b0, a_r[L].nx}) - 6'(FRAC_BITS);
    lg_v    = $signed({eg, a_r[L].fg});
    lx_v    = $signed({ex, a_r[L].fx});
    ds      = 17'sd32768 - $signed({1'b0, cfg.shape});
    lp_prod = ds * lg_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lp_r    <= lp_prod[LOG_W+16:16];
      lx_r    <= lx_v;
      sd_p0_r <= a_r[L].sd;
    end
  end

  // p = exp2(lp)
  exp_st_t e1_in;
  exp_st_t e1_r [1:L];

  always_comb begin
    e1_in.sd = sd_p0_r;
    e1_in.lx = lx_r;
    e1_in.n  = EXP_NW'($signed(lp_r[LP_W-1:L]));
    e1_in.f  = lp_r[L-1:0];
    e1_in.m  = MAN_W'(1) << Q30;
  end

  for (genvar k = 1; k <= L; k++) begin : g_exp1
    localparam logic [MAN_W-1:0] RT = root_val(k);
    if (k == 1) begin : g_first
      always_ff @(posedge clk) begin
        if (adv) e1_r[k] <= exp_adv(e1_in, RT, e1_in.f[L-k]);
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (adv) e1_r[k] <= exp_adv(e1_r[k-1], RT, e1_r[k-1].f[L-k]);
      end
    end
  end

  logic [P_W-1:0]          p_v;
  logic [7:0]              nn;
  logic [P_W-1:0]          p_r;
  logic signed [LOG_W-1:0] lx_p2_r;
  side_t                   sd_p2_r;

  always_comb begin
    nn = 8'(-e1_r[L].n);
    if (!e1_r[L].n[EXP_NW-1]) p_v = P_W'(e1_r[L].m) << e1_r[L].n[2:0];
    else p_v = P_W'(e1_r[L].m >> nn);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r     <= p_v;
      lx_p2_r <= e1_r[L].lx;
      sd_p2_r <= e1_r[L].sd;
    end
  end

  // |lx| * p in two partial products
  logic [AX_W-1:0] ax;
  logic [PR_W-1:0] lo_r;
  logic [PR_W-1:0] hi_r;
  side_t           sd_m1_r;

  assign ax = AX_W'(-lx_p2_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      lo_r    <= {{PH{1'b0}}, ax} * {{AX_W{1'b0}}, p_r[PH-1:0]};
      hi_r    <= {{PH{1'b0}}, ax} * {{(AX_W+PH-(P_W-PH)){1'b0}}, p_r[P_W-1:PH]};
      sd_m1_r <= sd_p2_r;
    end
  end

  logic [UT_W-1:0] ut_v;
  logic [QV_W-1:0] q_r;
  side_t           sd_m2_r;

  assign ut_v = {1'b0, hi_r, {PH{1'b0}}} + UT_W'(lo_r) + UT_W'((64'd1 << Q30) - 64'd1);

  always_ff @(posedge clk) begin
    if (adv) begin
      q_r     <= ut_v[UT_W-1:Q30];
      sd_m2_r <= sd_m1_r;
    end
  end

  // y = exp2(-q)
  logic signed [QV_W:0] t_v;
  exp_st_t              e2_in;
  exp_st_t              e2_r [1:L];

  always_comb begin
    t_v      = -$signed({1'b0, q_r});
    e2_in.sd = sd_m2_r;
    e2_in.lx = '0;
    e2_in.n  = EXP_NW'($signed(t_v[QV_W:L]));
    e2_in.f  = t_v[L-1:0];
    e2_in.m  = MAN_W'(1) << Q30;
  end

  for (genvar k = 1; k <= L; k++) begin : g_exp2
    localparam logic [MAN_W-1:0] RT = root_val(k);
    if (k == 1) begin : g_first
      always_ff @(posedge clk) begin
        if (adv) e2_r[k] <= exp_adv(e2_in, RT, e2_in.f[L-k]);
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (adv) e2_r[k] <= exp_adv(e2_r[k-1], RT, e2_r[k-1].f[L-k]);
      end
    end
  end

  logic [8:0]     sh;
  logic [Y_W-1:0] y_v;
  logic [Y_W-1:0] y_r;
  side_t          sd_y_r;

  always_comb begin
    sh = 9'(Q30 - FRAC_BITS) - 9'(e2_r[L].n);
    if (sh >= 9'(MAN_W)) y_v = '0;
    else y_v = Y_W'(e2_r[L].m >> sh);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      y_r    <= y_v;
      sd_y_r <= e2_r[L].sd;
    end
  end

  // scale, clamp, sign
  logic [Y_W+15:0]  sc_prod;
  logic [Y_W:0]     res_v;
  logic [POS_W-1:0] rc;
  res_item_t        out_v;
  res_item_t        res_r;

  always_comb begin
    sc_prod = {16'b0, y_r} * {{Y_W{1'b0}}, cfg.scale};
    res_v   = sc_prod[Y_W+15:15];
    rc      = (res_v > (Y_W+1)'(ONE_VAL)) ? POS_W'(ONE_VAL) : POS_W'(res_v);
    out_v.mapped = sd_y_r.neg ? POS_W'(-rc) : rc;
    out_v.dead   = sd_y_r.dead;
    if (sd_y_r.dead || sd_y_r.zero) out_v.mapped = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) res_r <= out_v;
  end

  assign res_item = res_r;

endmodule

FILE: rtl/dzc_outq.sv
module dzc_outq import dzc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  res_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output res_item_t head
);

  res_item_t        mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wptr_r;
  logic [OQ_AW-1:0] rptr_r;
  logic [OQ_AW:0]   cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == (OQ_AW+1)'(OQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + 1'b1;
      if (do_pop) rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_r + (OQ_AW+1)'(do_push) - (OQ_AW+1)'(do_pop);
    end
  end

endmodule

FILE: rtl/deadzone_expo_response_curve.sv
// items go from the in queue via log2, p, |log|*p, exp2(-q) and scale to the out queue
// throughput: one item per cycle unless the out queue is full, via pipelined log2/exp2
// two squarings or one root multiply per stage; two 20x17 partial products for |log|*p
// synchronous active-low reset empties both queues and the pipe, loads register defaults
`include "deadzone_expo_response_curve_assert.svh"
module deadzone_expo_response_curve import dzc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic [15:0]      in_raw_position,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [15:0]      out_mapped_position,
  output logic             out_inside_dead_band,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_data
);

  cfg_t      cfg_r;
  cfg_t      cfg_nxt;
  mid_item_t f_item;
  mid_item_t q_head;
  logic      q_empty;
  logic      q_pop;
  logic      res_full;
  logic      res_push;
  res_item_t res_item;
  res_item_t o_head;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_GAIN: begin
          if (cfg_data[14:0] < 15'(GAIN_MIN)) cfg_nxt.gain = 15'(GAIN_MIN);
          else if (cfg_data[14:0] > 15'(GAIN_MAX)) cfg_nxt.gain = 15'(GAIN_MAX);
          else cfg_nxt.gain = cfg_data[14:0];
        end
        CFG_SCALE: begin
          if (cfg_data < 16'(SCALE_MIN)) cfg_nxt.scale = 16'(SCALE_MIN);
          else if (cfg_data > 16'(SCALE_MAX)) cfg_nxt.scale = 16'(SCALE_MAX);
          else cfg_nxt.scale = cfg_data;
        end
        CFG_DEAD: begin
          if (cfg_data[13:0] > 14'(DEAD_MAX)) cfg_nxt.dead = 14'(DEAD_MAX);
          else cfg_nxt.dead = cfg_data[13:0];
        end
        CFG_BIAS: begin
          if ($signed(cfg_data) < -16'sd16384) cfg_nxt.bias = -16'sd16384;
          else if ($signed(cfg_data) > 16'sd16384) cfg_nxt.bias = 16'sd16384;
          else cfg_nxt.bias = $signed(cfg_data);
        end
        CFG_SHAPE: begin
          if (cfg_data < 16'(SHAPE_MIN)) cfg_nxt.shape = 16'(SHAPE_MIN);
          else if (cfg_data > 16'(SHAPE_MAX)) cfg_nxt.shape = 16'(SHAPE_MAX);
          else cfg_nxt.shape = cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain  <= 15'(GAIN_RST);
      cfg_r.scale <= 16'(SCALE_RST);
      cfg_r.dead  <= '0;
      cfg_r.bias  <= '0;
      cfg_r.shape <= 16'(SHAPE_RST);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dzc_front u_front (
    .raw_position (in_raw_position),
    .cfg          (cfg_r),
    .item         (f_item)
  );

  dzc_midq u_midq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_item (f_item),
    .full      (in_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  dzc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_item   (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .cfg      (cfg_r),
    .res_full (res_full),
    .res_push (res_push),
    .res_item (res_item)
  );

  dzc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_item (res_item),
    .full      (res_full),
    .pop       (out_pop),
    .empty     (out_empty),
    .head      (o_head)
  );

  assign out_mapped_position  = o_head.mapped;
  assign out_inside_dead_band = o_head.dead;

  `DZC_ASSERT(a_dead_zero, clk, rst_n, !out_empty && out_inside_dead_band |-> out_mapped_position == 16'd0, "dead band item with nonzero output")
  `DZC_ASSERT(a_out_range, clk, rst_n, !out_empty |-> ($signed(out_mapped_position) <= 16'sd16384 && $signed(out_mapped_position) >= -16'sd16384), "output beyond unit range")
  `DZC_ASSERT_NEXT(a_gain_sat, clk, rst_n, cfg_valid && cfg_index == 3'(CFG_GAIN), cfg_r.gain >= 15'(GAIN_MIN) && cfg_r.gain <= 15'(GAIN_MAX), "gain write not saturated")

endmodule
